>>> src/grid_graph_cell_numbering_assert.svh
// Assertion macros for the grid graph cell numbering block.
// Included by files that check their own logic; needs nothing else.
`ifndef GRID_GRAPH_CELL_NUMBERING_ASSERT_SVH
`define GRID_GRAPH_CELL_NUMBERING_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/gg_pkg.sv
// Shared types and constants for the grid graph cell numbering block.
// Used by the top level and the divider; depends on nothing.
package gg_pkg;

   localparam int LOC_W    = 12;
   localparam int ID_W     = 12;
   localparam int VAL_W    = 13;
   localparam int DIM_W    = 7;
   localparam int NCELL_W  = 14;
   localparam int LOC_SPAN = 4096;

   localparam logic [2:0] CMD_CLEAR  = 3'd0;
   localparam logic [2:0] CMD_MARK   = 3'd1;
   localparam logic [2:0] CMD_NUMBER = 3'd2;
   localparam logic [2:0] CMD_EDGES  = 3'd3;
   localparam logic [2:0] CMD_TO_ID  = 3'd4;
   localparam logic [2:0] CMD_TO_POS = 3'd5;
   localparam logic [2:0] CMD_DIST   = 3'd6;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_RANGE   = 2'd1;
   localparam logic [1:0] ST_UNNUM   = 2'd2;
   localparam logic [1:0] ST_BLOCKED = 2'd3;

   localparam logic [1:0] REG_ROWS = 2'd0;
   localparam logic [1:0] REG_COLS = 2'd1;
   localparam logic [1:0] REG_COST = 2'd2;

   typedef struct packed {
      logic             start;
      logic [LOC_W-1:0] dividend;
      logic [DIM_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [LOC_W-1:0] quot;
      logic [DIM_W-1:0] rem;
   } div_rsp_type;

endpackage

>>> src/gg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; sized by its width and depth parameters.
module gg_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

>>> src/gg_div.sv
// Restoring divider, one quotient bit per cycle, for location / cols.
// Depends on gg_pkg for widths and the request and response structs.
module gg_div (
   input  logic                clock,
   input  logic                reset,
   input  gg_pkg::div_req_type req,
   output gg_pkg::div_rsp_type rsp
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [3:0]               cnt_ff, cnt_in;
   logic [gg_pkg::DIM_W-1:0] rem_ff, rem_in;
   logic [gg_pkg::LOC_W-1:0] quo_ff, quo_in;
   logic [gg_pkg::DIM_W-1:0] dvs_ff, dvs_in;
   logic [gg_pkg::DIM_W:0]   trial;
   logic                     ge;

   assign trial = {rem_ff, quo_ff[gg_pkg::LOC_W-1]};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 4'(gg_pkg::LOC_W);
         rem_in  = '0;
         quo_in  = req.dividend;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? gg_pkg::DIM_W'(trial - {1'b0, dvs_ff}) : trial[gg_pkg::DIM_W-1:0];
         quo_in = {quo_ff[gg_pkg::LOC_W-2:0], ge};
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;
   assign rsp.rem  = rem_ff;

endmodule

>>> src/grid_graph_cell_numbering.sv
// Top level of the grid graph cell numbering block: sequencer, tables, ports.
// Depends on gg_pkg, gg_ram, gg_div and the assertion macro header.
//
// The block takes one command transaction at a time and returns its results in
// order through an output register. After reset, and for every clear command,
// the obstacle map is swept one entry a cycle, and no command is taken during
// the reset sweep. Numbering reads one map entry a cycle. Row and column come
// from a serial divider, used by id-to-position, distance and edge listing;
// edge listing gives one result per edge found, or one if none is found.
module grid_graph_cell_numbering #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [11:0] req_loc,
   input  logic [11:0] req_id_a,
   input  logic [11:0] req_id_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [11:0] rsp_edge_from,
   output logic [11:0] rsp_edge_to,
   output logic [7:0]  rsp_edge_cost,
   output logic        rsp_edge_valid,
   output logic [12:0] rsp_value,
   output logic [5:0]  rsp_row,
   output logic [5:0]  rsp_col,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int CELLS = MAX_ROWS * MAX_COLS;
   localparam int DEPTH = (CELLS < gg_pkg::LOC_SPAN) ? CELLS : gg_pkg::LOC_SPAN;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [12:0] LAST_ENTRY = 13'(DEPTH - 1);

   localparam logic [4:0] S_SWEEP  = 5'd0;
   localparam logic [4:0] S_IDLE   = 5'd1;
   localparam logic [4:0] S_DECODE = 5'd2;
   localparam logic [4:0] S_NUM    = 5'd3;
   localparam logic [4:0] S_CELL   = 5'd4;
   localparam logic [4:0] S_ID4    = 5'd5;
   localparam logic [4:0] S_OWN    = 5'd6;
   localparam logic [4:0] S_DIV3   = 5'd7;
   localparam logic [4:0] S_NB_RD  = 5'd8;
   localparam logic [4:0] S_NB_CAP = 5'd9;
   localparam logic [4:0] S_PICK   = 5'd10;
   localparam logic [4:0] S_EDGE   = 5'd11;
   localparam logic [4:0] S_LA     = 5'd12;
   localparam logic [4:0] S_DIVA   = 5'd13;
   localparam logic [4:0] S_LB     = 5'd14;
   localparam logic [4:0] S_DIVB   = 5'd15;
   localparam logic [4:0] S_EMIT   = 5'd16;

   function automatic logic [6:0] clamp_dim(input logic [6:0] v, input int maxv);
      logic [6:0] r;
      r = v;
      if (v == 7'd0) begin
         r = 7'd1;
      end else if (int'(v) > maxv) begin
         r = 7'(maxv);
      end
      return r;
   endfunction

   logic [4:0]  state_ff, state_in;
   logic [2:0]  cmd_ff, cmd_in;
   logic [11:0] loc_ff, loc_in, ia_ff, ia_in, ib_ff, ib_in;
   logic [6:0]  rows_ff, rows_in, cols_ff, cols_in;
   logic [7:0]  cost_ff, cost_in;
   logic [13:0] ncell_ff;
   logic        numbered_ff, numbered_in;
   logic [12:0] fcount_ff, fcount_in;
   logic [12:0] sweep_ff, sweep_in;
   logic        clr_emit_ff, clr_emit_in;
   logic [13:0] p_ff, p_in;
   logic        pv_ff, pv_in;
   logic [11:0] pd_ff, pd_in;
   logic [12:0] idc_ff, idc_in;
   logic [11:0] own_ff, own_in;
   logic [11:0] rq_ff, rq_in;
   logic [6:0]  cr_ff, cr_in;
   logic [3:0]  mask_ff, mask_in;
   logic [1:0]  k_ff, k_in;
   logic [1:0]  pst_ff, pst_in;
   logic [12:0] pval_ff, pval_in;
   logic [5:0]  prow_ff, prow_in, pcol_ff, pcol_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [11:0] rsp_from_ff, rsp_from_in, rsp_to_ff, rsp_to_in;
   logic [7:0]  rsp_cost_ff, rsp_cost_in;
   logic        rsp_ev_ff, rsp_ev_in;
   logic [12:0] rsp_value_ff, rsp_value_in;
   logic [5:0]  rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        fm_we, fm_re;
   logic [11:0] fm_waddr, fm_raddr;
   logic        fm_wdata;
   logic [0:0]  fm_rdata;
   logic        l2i_we, l2i_re;
   logic [11:0] l2i_waddr, l2i_raddr, l2i_wdata, l2i_rdata;
   logic        i2l_we, i2l_re;
   logic [11:0] i2l_waddr, i2l_raddr, i2l_wdata, i2l_rdata;

   gg_pkg::div_req_type div_req;
   gg_pkg::div_rsp_type div_rsp;

   logic        cfg_wr;
   logic        push_ok;
   logic        accept;
   logic [11:0] cols12;
   logic [1:0]  sel;
   logic [3:0]  mask_rest;
   logic [11:0] dr;
   logic [6:0]  dc;

   function automatic logic [11:0] nb_loc(input logic [1:0] k, input logic [11:0] l,
                                         input logic [11:0] c);
      logic [11:0] r;
      unique case (k)
         2'd0: r = l - c;
         2'd1: r = l + c;
         2'd2: r = l + 12'd1;
         default: r = l - 12'd1;
      endcase
      return r;
   endfunction

   function automatic logic inbound(input logic [1:0] k, input logic [11:0] rq,
                                    input logic [6:0] cr, input logic [6:0] nr,
                                    input logic [6:0] nc);
      logic r;
      unique case (k)
         2'd0: r = rq != 12'd0;
         2'd1: r = (13'(rq) + 13'd1) < 13'(nr);
         2'd2: r = (8'(cr) + 8'd1) < 8'(nc);
         default: r = cr != 7'd0;
      endcase
      return r;
   endfunction

   assign cfg_wr  = psel && penable && pwrite && pready;
   assign pready  = 1'b1;
   assign push_ok = !rsp_valid_ff || !rsp_stall;
   assign accept  = req_valid && !req_stall;
   assign req_stall = state_ff != S_IDLE;
   assign cols12  = {5'd0, cols_ff};

   always_comb begin
      unique case (paddr[3:2])
         gg_pkg::REG_ROWS: prdata = {25'd0, rows_ff};
         gg_pkg::REG_COLS: prdata = {25'd0, cols_ff};
         gg_pkg::REG_COST: prdata = {24'd0, cost_ff};
         default:          prdata = 32'd0;
      endcase
   end

   always_comb begin
      if (mask_ff[0]) begin
         sel = 2'd0;
      end else if (mask_ff[1]) begin
         sel = 2'd1;
      end else if (mask_ff[2]) begin
         sel = 2'd2;
      end else begin
         sel = 2'd3;
      end
   end

   assign mask_rest = mask_ff & ~(4'd1 << k_ff);
   assign dr = (rq_ff > div_rsp.quot) ? rq_ff - div_rsp.quot : div_rsp.quot - rq_ff;
   assign dc = (cr_ff > div_rsp.rem) ? cr_ff - div_rsp.rem : div_rsp.rem - cr_ff;

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      loc_in      = loc_ff;
      ia_in       = ia_ff;
      ib_in       = ib_ff;
      rows_in     = rows_ff;
      cols_in     = cols_ff;
      cost_in     = cost_ff;
      numbered_in = numbered_ff;
      fcount_in   = fcount_ff;
      sweep_in    = sweep_ff;
      clr_emit_in = clr_emit_ff;
      p_in        = p_ff;
      pv_in       = pv_ff;
      pd_in       = pd_ff;
      idc_in      = idc_ff;
      own_in      = own_ff;
      rq_in       = rq_ff;
      cr_in       = cr_ff;
      mask_in     = mask_ff;
      k_in        = k_ff;
      pst_in      = pst_ff;
      pval_in     = pval_ff;
      prow_in     = prow_ff;
      pcol_in     = pcol_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_from_in   = rsp_from_ff;
      rsp_to_in     = rsp_to_ff;
      rsp_cost_in   = rsp_cost_ff;
      rsp_ev_in     = rsp_ev_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_last_in   = rsp_last_ff;

      fm_we = 1'b0;  fm_waddr = loc_ff;  fm_wdata = 1'b0;
      fm_re = 1'b0;  fm_raddr = loc_ff;
      l2i_we = 1'b0; l2i_waddr = pd_ff; l2i_wdata = idc_ff[11:0];
      l2i_re = 1'b0; l2i_raddr = loc_ff;
      i2l_we = 1'b0; i2l_waddr = idc_ff[11:0]; i2l_wdata = pd_ff;
      i2l_re = 1'b0; i2l_raddr = ia_ff;
      div_req.start    = 1'b0;
      div_req.dividend = loc_ff;
      div_req.divisor  = cols_ff;

      if (cfg_wr) begin
         unique case (paddr[3:2])
            gg_pkg::REG_ROWS: begin
               rows_in     = clamp_dim(pwdata[6:0], MAX_ROWS);
               numbered_in = 1'b0;
            end
            gg_pkg::REG_COLS: begin
               cols_in     = clamp_dim(pwdata[6:0], MAX_COLS);
               numbered_in = 1'b0;
            end
            gg_pkg::REG_COST: cost_in = pwdata[7:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_SWEEP: begin
            fm_we    = 1'b1;
            fm_waddr = sweep_ff[11:0];
            fm_wdata = 1'b1;
            if (sweep_ff == LAST_ENTRY) begin
               sweep_in = '0;
               if (clr_emit_ff) begin
                  clr_emit_in = 1'b0;
                  pst_in      = gg_pkg::ST_OK;
                  state_in    = S_EMIT;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               sweep_in = sweep_ff + 13'd1;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd_in   = req_cmd;
               loc_in   = req_loc;
               ia_in    = req_id_a;
               ib_in    = req_id_b;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            pval_in  = '0;
            prow_in  = '0;
            pcol_in  = '0;
            pst_in   = gg_pkg::ST_OK;
            state_in = S_EMIT;
            unique case (cmd_ff)
               gg_pkg::CMD_CLEAR: begin
                  fcount_in   = '0;
                  numbered_in = 1'b0;
                  clr_emit_in = 1'b1;
                  state_in    = S_SWEEP;
               end
               gg_pkg::CMD_MARK: begin
                  if ({2'd0, loc_ff} >= ncell_ff) begin
                     pst_in = gg_pkg::ST_RANGE;
                  end else begin
                     fm_we       = 1'b1;
                     numbered_in = 1'b0;
                  end
               end
               gg_pkg::CMD_NUMBER: begin
                  p_in     = '0;
                  pv_in    = 1'b0;
                  idc_in   = '0;
                  state_in = S_NUM;
               end
               gg_pkg::CMD_EDGES, gg_pkg::CMD_TO_ID: begin
                  if ({2'd0, loc_ff} >= ncell_ff) begin
                     pst_in = gg_pkg::ST_RANGE;
                  end else if (!numbered_ff) begin
                     pst_in = gg_pkg::ST_UNNUM;
                  end else begin
                     fm_re    = 1'b1;
                     state_in = S_CELL;
                  end
               end
               gg_pkg::CMD_TO_POS, gg_pkg::CMD_DIST: begin
                  if (!numbered_ff) begin
                     pst_in = gg_pkg::ST_UNNUM;
                  end else if ({1'b0, ia_ff} >= fcount_ff ||
                               (cmd_ff == gg_pkg::CMD_DIST && {1'b0, ib_ff} >= fcount_ff))
                  begin
                     pst_in = gg_pkg::ST_RANGE;
                  end else begin
                     i2l_re   = 1'b1;
                     state_in = S_LA;
                  end
               end
               default: pst_in = gg_pkg::ST_RANGE;
            endcase
         end
         S_NUM: begin
            if (p_ff < ncell_ff) begin
               fm_re    = 1'b1;
               fm_raddr = p_ff[11:0];
               p_in     = p_ff + 14'd1;
               pv_in    = 1'b1;
               pd_in    = p_ff[11:0];
            end else begin
               pv_in = 1'b0;
            end
            if (pv_ff && fm_rdata[0]) begin
               l2i_we = 1'b1;
               i2l_we = 1'b1;
               idc_in = idc_ff + 13'd1;
            end
            if (p_ff >= ncell_ff && !pv_ff) begin
               fcount_in   = idc_ff;
               numbered_in = 1'b1;
               pval_in     = idc_ff;
               state_in    = S_EMIT;
            end
         end
         S_CELL: begin
            if (!fm_rdata[0]) begin
               pst_in   = gg_pkg::ST_BLOCKED;
               state_in = S_EMIT;
            end else begin
               l2i_re   = 1'b1;
               state_in = (cmd_ff == gg_pkg::CMD_TO_ID) ? S_ID4 : S_OWN;
            end
         end
         S_ID4: begin
            pval_in  = {1'b0, l2i_rdata};
            state_in = S_EMIT;
         end
         S_OWN: begin
            own_in        = l2i_rdata;
            div_req.start = 1'b1;
            state_in      = S_DIV3;
         end
         S_DIV3: begin
            if (div_rsp.done) begin
               rq_in    = div_rsp.quot;
               cr_in    = div_rsp.rem;
               k_in     = 2'd0;
               mask_in  = '0;
               state_in = S_NB_RD;
            end
         end
         S_NB_RD: begin
            if (inbound(k_ff, rq_ff, cr_ff, rows_ff, cols_ff)) begin
               fm_re    = 1'b1;
               fm_raddr = nb_loc(k_ff, loc_ff, cols12);
               state_in = S_NB_CAP;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = (k_ff == 2'd3) ? S_PICK : S_NB_RD;
            end
         end
         S_NB_CAP: begin
            mask_in[k_ff] = fm_rdata[0];
            k_in          = k_ff + 2'd1;
            state_in      = (k_ff == 2'd3) ? S_PICK : S_NB_RD;
         end
         S_PICK: begin
            if (mask_ff == 4'd0) begin
               state_in = S_EMIT;
            end else begin
               l2i_re    = 1'b1;
               l2i_raddr = nb_loc(sel, loc_ff, cols12);
               k_in      = sel;
               state_in  = S_EDGE;
            end
         end
         S_EDGE: begin
            if (push_ok) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = gg_pkg::ST_OK;
               rsp_from_in   = own_ff;
               rsp_to_in     = l2i_rdata;
               rsp_cost_in   = cost_ff;
               rsp_ev_in     = 1'b1;
               rsp_value_in  = '0;
               rsp_row_in    = '0;
               rsp_col_in    = '0;
               rsp_last_in   = mask_rest == 4'd0;
               mask_in       = mask_rest;
               state_in      = (mask_rest == 4'd0) ? S_IDLE : S_PICK;
            end
         end
         S_LA: begin
            div_req.start    = 1'b1;
            div_req.dividend = i2l_rdata;
            state_in         = S_DIVA;
         end
         S_DIVA: begin
            if (div_rsp.done) begin
               rq_in = div_rsp.quot;
               cr_in = div_rsp.rem;
               if (cmd_ff == gg_pkg::CMD_TO_POS) begin
                  prow_in  = div_rsp.quot[5:0];
                  pcol_in  = div_rsp.rem[5:0];
                  state_in = S_EMIT;
               end else begin
                  i2l_re    = 1'b1;
                  i2l_raddr = ib_ff;
                  state_in  = S_LB;
               end
            end
         end
         S_LB: begin
            div_req.start    = 1'b1;
            div_req.dividend = i2l_rdata;
            state_in         = S_DIVB;
         end
         S_DIVB: begin
            if (div_rsp.done) begin
               pval_in  = 13'(dr) + 13'(dc);
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (push_ok) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pst_ff;
               rsp_from_in   = '0;
               rsp_to_in     = '0;
               rsp_cost_in   = '0;
               rsp_ev_in     = 1'b0;
               rsp_value_in  = pval_ff;
               rsp_row_in    = prow_ff;
               rsp_col_in    = pcol_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         rows_ff      <= clamp_dim(7'd64, MAX_ROWS);
         cols_ff      <= clamp_dim(7'd64, MAX_COLS);
         cost_ff      <= 8'd1;
         numbered_ff  <= 1'b0;
         fcount_ff    <= '0;
         sweep_ff     <= '0;
         clr_emit_ff  <= 1'b0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         cost_ff      <= cost_in;
         numbered_ff  <= numbered_in;
         fcount_ff    <= fcount_in;
         sweep_ff     <= sweep_in;
         clr_emit_ff  <= clr_emit_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ncell_ff      <= 14'(rows_ff * cols_ff);
      cmd_ff        <= cmd_in;
      loc_ff        <= loc_in;
      ia_ff         <= ia_in;
      ib_ff         <= ib_in;
      p_ff          <= p_in;
      pd_ff         <= pd_in;
      idc_ff        <= idc_in;
      own_ff        <= own_in;
      rq_ff         <= rq_in;
      cr_ff         <= cr_in;
      mask_ff       <= mask_in;
      k_ff          <= k_in;
      pst_ff        <= pst_in;
      pval_ff       <= pval_in;
      prow_ff       <= prow_in;
      pcol_ff       <= pcol_in;
      rsp_status_ff <= rsp_status_in;
      rsp_from_ff   <= rsp_from_in;
      rsp_to_ff     <= rsp_to_in;
      rsp_cost_ff   <= rsp_cost_in;
      rsp_ev_ff     <= rsp_ev_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_last_ff   <= rsp_last_in;
   end

   gg_ram #(.WIDTH(1), .DEPTH(DEPTH), .AW(AW)) u_free_map (
      .clock (clock),
      .we    (fm_we),
      .waddr (fm_waddr[AW-1:0]),
      .wdata (fm_wdata),
      .re    (fm_re),
      .raddr (fm_raddr[AW-1:0]),
      .rdata (fm_rdata)
   );

   gg_ram #(.WIDTH(gg_pkg::ID_W), .DEPTH(DEPTH), .AW(AW)) u_loc_to_id (
      .clock (clock),
      .we    (l2i_we),
      .waddr (l2i_waddr[AW-1:0]),
      .wdata (l2i_wdata),
      .re    (l2i_re),
      .raddr (l2i_raddr[AW-1:0]),
      .rdata (l2i_rdata)
   );

   gg_ram #(.WIDTH(gg_pkg::LOC_W), .DEPTH(DEPTH), .AW(AW)) u_id_to_loc (
      .clock (clock),
      .we    (i2l_we),
      .waddr (i2l_waddr[AW-1:0]),
      .wdata (i2l_wdata),
      .re    (i2l_re),
      .raddr (i2l_raddr[AW-1:0]),
      .rdata (i2l_rdata)
   );

   gg_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_edge_from  = rsp_from_ff;
   assign rsp_edge_to    = rsp_to_ff;
   assign rsp_edge_cost  = rsp_cost_ff;
   assign rsp_edge_valid = rsp_ev_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_row        = rsp_row_ff;
   assign rsp_col        = rsp_col_ff;
   assign rsp_last       = rsp_last_ff;

`include "grid_graph_cell_numbering_assert.svh"

   `GG_ASSERT_NOW(a_edge_ok, clock, reset, rsp_valid_ff && rsp_ev_ff, rsp_status_ff == gg_pkg::ST_OK, "Edge transaction carries a failure status.")
   `GG_ASSERT_NOW(a_numbered_src, clock, reset, $rose(numbered_ff), $past(state_ff) == S_NUM, "Numbered flag set outside the numbering pass.")
   `GG_ASSERT_NEXT(a_div_start, clock, reset, div_req.start, !div_rsp.done, "Divider finished one cycle after start.")

endmodule

>>> tb/sv/grid_graph_cell_numbering_tb.sv
// Self-checking testbench for the grid graph cell numbering block.
// Drives command transactions and register writes, predicts every result and compares.
// Depends on gg_pkg and the grid_graph_cell_numbering top level.
module grid_graph_cell_numbering_tb;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] edge_from;
      logic [11:0] edge_to;
      logic [7:0]  edge_cost;
      logic        edge_valid;
      logic [12:0] value;
      logic [5:0]  row;
      logic [5:0]  col;
      logic        last;
   } grid_rsp_type;

   typedef struct {
      logic [2:0]  cmd;
      logic [11:0] loc;
      logic [11:0] id_a;
      logic [11:0] id_b;
      logic        has_exp;
      logic [1:0]  exp_status;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_cmd = '0;
   logic [11:0] req_loc = '0;
   logic [11:0] req_id_a = '0;
   logic [11:0] req_id_b = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [11:0] rsp_edge_from, rsp_edge_to;
   logic [7:0]  rsp_edge_cost;
   logic        rsp_edge_valid;
   logic [12:0] rsp_value;
   logic [5:0]  rsp_row, rsp_col;
   logic        rsp_last;
   logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   grid_graph_cell_numbering u_top (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   logic        cell_free [4096];
   logic [12:0] cell_id [4096];
   logic [11:0] id_cell [4096];
   int          n_free;
   bit          is_numbered;
   int          n_rows, n_cols, cost;

   grid_rsp_type pending_rsp[$];
   int          mismatches = 0;
   bit          calm = 1'b0;
   bit          hold_rsp = 1'b0;

   function automatic int clamp_dim(int v);
      if (v < 1) return 1;
      if (v > 64) return 64;
      return v;
   endfunction

   function automatic grid_rsp_type blank_rsp(logic [1:0] st);
      grid_rsp_type r = '0;
      r.status = st;
      r.last = 1'b1;
      return r;
   endfunction

   task automatic predict_cmd(logic [2:0] cmd, logic [11:0] loc, logic [11:0] ia,
                              logic [11:0] ib);
      int ncell, id, r, c, n, la, lb, d;
      int nb[4];
      grid_rsp_type x;
      ncell = n_rows * n_cols;
      x = blank_rsp(gg_pkg::ST_OK);
      case (cmd)
         gg_pkg::CMD_CLEAR: begin
            foreach (cell_free[i]) cell_free[i] = 1'b1;
            n_free = 0;
            is_numbered = 0;
            pending_rsp.push_back(x);
         end
         gg_pkg::CMD_MARK: begin
            if (loc >= ncell) x.status = gg_pkg::ST_RANGE;
            else begin
               cell_free[loc] = 1'b0;
               is_numbered = 0;
            end
            pending_rsp.push_back(x);
         end
         gg_pkg::CMD_NUMBER: begin
            id = 0;
            for (int p = 0; p < ncell; p++) begin
               if (cell_free[p]) begin
                  cell_id[p] = 13'(id);
                  id_cell[id] = 12'(p);
                  id++;
               end
            end
            n_free = id;
            is_numbered = 1;
            x.value = 13'(id);
            pending_rsp.push_back(x);
         end
         gg_pkg::CMD_EDGES, gg_pkg::CMD_TO_ID: begin
            if (loc >= ncell) x.status = gg_pkg::ST_RANGE;
            else if (!is_numbered) x.status = gg_pkg::ST_UNNUM;
            else if (!cell_free[loc]) x.status = gg_pkg::ST_BLOCKED;
            if (x.status != gg_pkg::ST_OK || cmd == gg_pkg::CMD_TO_ID) begin
               if (x.status == gg_pkg::ST_OK) x.value = cell_id[loc];
               pending_rsp.push_back(x);
            end else begin
               r = int'(loc) / n_cols;
               c = int'(loc) % n_cols;
               n = 0;
               if (r > 0 && cell_free[loc - n_cols]) nb[n++] = loc - n_cols;
               if (r + 1 < n_rows && cell_free[loc + n_cols]) nb[n++] = loc + n_cols;
               if (c + 1 < n_cols && cell_free[loc + 1]) nb[n++] = loc + 1;
               if (c > 0 && cell_free[loc - 1]) nb[n++] = loc - 1;
               if (n == 0) pending_rsp.push_back(x);
               for (int k = 0; k < n; k++) begin
                  x = '0;
                  x.edge_from = cell_id[loc][11:0];
                  x.edge_to = cell_id[nb[k]][11:0];
                  x.edge_cost = 8'(cost);
                  x.edge_valid = 1'b1;
                  x.last = (k == n - 1);
                  pending_rsp.push_back(x);
               end
            end
         end
         gg_pkg::CMD_TO_POS, gg_pkg::CMD_DIST: begin
            if (!is_numbered) x.status = gg_pkg::ST_UNNUM;
            else if (ia >= n_free || (cmd == gg_pkg::CMD_DIST && ib >= n_free))
               x.status = gg_pkg::ST_RANGE;
            else begin
               la = int'(id_cell[ia]);
               if (cmd == gg_pkg::CMD_TO_POS) begin
                  x.row = 6'(la / n_cols);
                  x.col = 6'(la % n_cols);
               end else begin
                  lb = int'(id_cell[ib]);
                  d = (la / n_cols > lb / n_cols) ? la / n_cols - lb / n_cols
                                                  : lb / n_cols - la / n_cols;
                  d += (la % n_cols > lb % n_cols) ? la % n_cols - lb % n_cols
                                                   : lb % n_cols - la % n_cols;
                  x.value = 13'(d);
               end
            end
            pending_rsp.push_back(x);
         end
         default: begin
            x.status = gg_pkg::ST_RANGE;
            pending_rsp.push_back(x);
         end
      endcase
   endtask

   task automatic write_reg(logic [1:0] idx, int val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         gg_pkg::REG_ROWS: begin n_rows = clamp_dim(val & 'h7f); is_numbered = 0; end
         gg_pkg::REG_COLS: begin n_cols = clamp_dim(val & 'h7f); is_numbered = 0; end
         default: cost = val & 'hff;
      endcase
   endtask

   task automatic send_cmd(logic [2:0] cmd, logic [11:0] loc, logic [11:0] ia,
                           logic [11:0] ib, bit idle_ok);
      if (idle_ok && !calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_loc <= loc;
      req_id_a <= ia;
      req_id_b <= ib;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_cmd(cmd, loc, ia, ib);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // The checker samples at the rising edge; the stall is updated in the same step.
   always @(posedge clock) begin
      grid_rsp_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_status, rsp_edge_from, rsp_edge_to, rsp_edge_cost, rsp_edge_valid,
                rsp_value, rsp_row, rsp_col, rsp_last};
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transaction %h", got);
         end else begin
            want = pending_rsp.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %h actual %h", want, got);
            end
         end
      end
      if (hold_rsp) rsp_stall <= 1'b1;
      else if (calm) rsp_stall <= 1'b0;
      else if (rsp_stall) rsp_stall <= ($urandom_range(0, 2) != 0);
      else rsp_stall <= ($urandom_range(0, 5) == 0);
   end

   // The long hold starts once the reset sweep is over and commands are flowing.
   initial begin
      wait (reset == 1'b0);
      repeat (4105) @(posedge clock);
      hold_rsp = 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      #4000000;
      $display("simulation failed");
      $finish;
   end

   stim_row_type dir_rows[$];

   task automatic add_row(logic [2:0] cmd, int loc, int ia, int ib, bit he, logic [1:0] es);
      stim_row_type s;
      s.cmd = cmd; s.loc = 12'(loc); s.id_a = 12'(ia); s.id_b = 12'(ib);
      s.has_exp = he; s.exp_status = es;
      dir_rows.push_back(s);
   endtask

   initial begin
      int dims[] = '{1, 64, 0, 127, 3, 8, 5};
      int cmd, k, n;
      foreach (cell_free[i]) cell_free[i] = 1'b1;
      foreach (cell_id[i]) cell_id[i] = '0;
      foreach (id_cell[i]) id_cell[i] = '0;
      n_free = 0; is_numbered = 0; n_rows = 64; n_cols = 64; cost = 1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      add_row(gg_pkg::CMD_TO_ID, 0, 0, 0, 1, gg_pkg::ST_UNNUM);
      add_row(gg_pkg::CMD_TO_POS, 0, 0, 0, 1, gg_pkg::ST_UNNUM);
      add_row(gg_pkg::CMD_DIST, 0, 0, 0, 1, gg_pkg::ST_UNNUM);
      add_row(gg_pkg::CMD_EDGES, 4095, 0, 0, 1, gg_pkg::ST_UNNUM);
      add_row(gg_pkg::CMD_MARK, 0, 0, 0, 1, gg_pkg::ST_OK);
      add_row(gg_pkg::CMD_MARK, 4095, 0, 0, 1, gg_pkg::ST_OK);
      add_row(gg_pkg::CMD_MARK, 65, 4095, 4095, 1, gg_pkg::ST_OK);
      add_row(gg_pkg::CMD_EDGES, 0, 0, 0, 1, gg_pkg::ST_UNNUM);
      add_row(gg_pkg::CMD_NUMBER, 0, 0, 0, 0, gg_pkg::ST_OK);
      add_row(gg_pkg::CMD_EDGES, 0, 0, 0, 1, gg_pkg::ST_BLOCKED);
      add_row(gg_pkg::CMD_EDGES, 1, 0, 0, 0, gg_pkg::ST_OK);
      add_row(gg_pkg::CMD_EDGES, 64, 0, 0, 0, gg_pkg::ST_OK);
      add_row(gg_pkg::CMD_EDGES, 66, 0, 0, 0, gg_pkg::ST_OK);
      add_row(gg_pkg::CMD_TO_ID, 4094, 0, 0, 0, gg_pkg::ST_OK);
      add_row(gg_pkg::CMD_TO_POS, 0, 4092, 0, 0, gg_pkg::ST_OK);
      add_row(gg_pkg::CMD_TO_POS, 0, 4093, 0, 1, gg_pkg::ST_RANGE);
      add_row(gg_pkg::CMD_DIST, 0, 0, 4092, 0, gg_pkg::ST_OK);
      add_row(gg_pkg::CMD_DIST, 0, 0, 4095, 1, gg_pkg::ST_RANGE);
      add_row(3'd7, 4095, 4095, 4095, 1, gg_pkg::ST_RANGE);
      add_row(gg_pkg::CMD_MARK, 65, 0, 0, 1, gg_pkg::ST_OK);
      add_row(gg_pkg::CMD_TO_ID, 1, 0, 0, 1, gg_pkg::ST_UNNUM);
      add_row(gg_pkg::CMD_CLEAR, 0, 0, 0, 1, gg_pkg::ST_OK);
      foreach (dir_rows[i]) begin
         send_cmd(dir_rows[i].cmd, dir_rows[i].loc, dir_rows[i].id_a, dir_rows[i].id_b, 1);
         if (dir_rows[i].has_exp && pending_rsp[$].status !== dir_rows[i].exp_status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("table row %0d: expected status %0d, predictor %0d", i,
                        dir_rows[i].exp_status, pending_rsp[$].status);
         end
      end
      drain();

      for (int ph = 0; ph < 7; ph++) begin
         write_reg(gg_pkg::REG_ROWS, dims[ph]);
         write_reg(gg_pkg::REG_COLS, dims[(ph + 3) % 7]);
         write_reg(gg_pkg::REG_COST, (ph == 0) ? 0 : (ph == 1) ? 255 : $urandom_range(0, 255));
         if (ph == 6) calm = 1'b1;
         send_cmd(gg_pkg::CMD_CLEAR, 12'd0, 12'd0, 12'd0, 1);
         for (k = 0; k < 26; k++) begin
            if (k == 8 || k == 20) cmd = gg_pkg::CMD_NUMBER;
            else if (k < 8)
               cmd = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : gg_pkg::CMD_MARK;
            else cmd = $urandom_range(0, 9) == 0 ? $urandom_range(0, 7) : $urandom_range(3, 6);
            if (cmd == gg_pkg::CMD_NUMBER && k != 8 && k != 20) cmd = gg_pkg::CMD_EDGES;
            if (cmd == gg_pkg::CMD_CLEAR && k > 8) cmd = gg_pkg::CMD_TO_ID;
            n = n_rows * n_cols;
            send_cmd(3'(cmd),
                     12'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                     : $urandom_range(0, n - 1)),
                     12'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                     : $urandom_range(0, n_free)),
                     12'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                     : $urandom_range(0, n_free)),
                     1);
         end
         drain();
      end

      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
